FILE: rtl/core/lvs_pkg.sv
// Shared types and constants of the Laplacian-variance sharpness meter.
// Used by lvs_var_unit and laplacian_variance_sharpness; depends on nothing.
package lvs_pkg;

	// Fixed widths of the external words and of the Laplacian terms
	localparam int PIX_W   = 8;
	localparam int CFG_W   = 9;
	localparam int CFG_IDX_W = 1;
	localparam int VAR_W   = 28;
	localparam int CNT_W   = 16;
	localparam int LAP_W   = 11;
	localparam int LAPSQ_W = 20;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Reset value of both frame dimensions
	localparam logic [CFG_W-1:0] DIM_RESET = 9'd112;

	// Pixel path sequencer
	typedef enum logic [1:0] {
		P_IDLE,
		P_EXEC,
		P_CALC,
		P_EMIT
	} pix_state_t;

	// Variance unit sequencer
	typedef enum logic [2:0] {
		V_IDLE,
		V_NS2,
		V_SS,
		V_SUB,
		V_NN,
		V_DIV,
		V_DONE
	} var_state_t;

endpackage

FILE: rtl/core/lvs_var_unit.sv
// Iterative variance unit: floor(256*(n*S2 - S^2)/n^2) with one shift-add
// multiplier and a restoring divider, one bit per cycle. Depends on lvs_pkg.
module lvs_var_unit import lvs_pkg::*; #(
	parameter int TW = 16,
	parameter int SW = 27,
	parameter int SQW = 36
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [TW-1:0]         n,
	input  logic signed [SW-1:0]  s,
	input  logic [SQW-1:0]        s2,
	output logic                  done,
	output logic [VAR_W-1:0]      quotient
);

	localparam int MW  = SW - 1;
	localparam int PW  = 2 * TW + 20;
	localparam int DW  = 2 * TW;
	localparam int QW  = PW + 8;
	localparam int CNW = $clog2(QW + 1);

	var_state_t state_q, state_nxt;

	logic [CNW-1:0] cnt_q;
	logic [PW-1:0]  acc_q, mcand_q, p1_q, acc_nxt;
	logic [MW-1:0]  mplier_q, smag_q;
	logic [TW-1:0]  n_q;
	logic [DW-1:0]  den_q, rem_q;
	logic [QW-1:0]  dvd_q;
	logic [VAR_W-1:0] quo_q;
	logic [DW:0]    sh;
	logic [DW+1:0]  diff;
	logic           last;
	logic [MW-1:0]  smag_in;

	// One shift-add step and one restoring division step
	always_comb begin
		acc_nxt = mplier_q[0] ? acc_q + mcand_q : acc_q;
		sh      = {rem_q, dvd_q[QW-1]};
		diff    = {1'b0, sh} - {2'b00, den_q};
		smag_in = s[SW-1] ? MW'(-s) : MW'(s);
	end

	// Iteration count of the current phase reached
	always_comb begin
		case (state_q)
			V_NS2:   last = (cnt_q == CNW'(TW - 1));
			V_SS:    last = (cnt_q == CNW'(MW - 1));
			V_NN:    last = (cnt_q == CNW'(TW - 1));
			V_DIV:   last = (cnt_q == CNW'(QW - 1));
			default: last = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			V_IDLE:  if (start) state_nxt = V_NS2;
			V_NS2:   if (last) state_nxt = V_SS;
			V_SS:    if (last) state_nxt = V_SUB;
			V_SUB:   state_nxt = V_NN;
			V_NN:    if (last) state_nxt = V_DIV;
			V_DIV:   if (last) state_nxt = V_DONE;
			V_DONE:  state_nxt = V_IDLE;
			default: state_nxt = V_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		done     = (state_q == V_DONE);
		quotient = quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= V_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			V_IDLE: begin
				n_q      <= n;
				smag_q   <= smag_in;
				acc_q    <= '0;
				mcand_q  <= PW'(s2);
				mplier_q <= MW'(n);
				cnt_q    <= '0;
			end
			V_NS2, V_SS, V_NN: begin
				acc_q    <= acc_nxt;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				cnt_q    <= cnt_q + CNW'(1);
				if (last) begin
					cnt_q <= '0;
					if (state_q == V_NS2) begin
						p1_q     <= acc_nxt;
						acc_q    <= '0;
						mcand_q  <= PW'(smag_q);
						mplier_q <= smag_q;
					end
					if (state_q == V_NN) begin
						den_q <= acc_nxt[DW-1:0];
						rem_q <= '0;
						quo_q <= '0;
					end
				end
			end
			V_SUB: begin
				dvd_q    <= {p1_q - acc_q, 8'h00};
				acc_q    <= '0;
				mcand_q  <= PW'(n_q);
				mplier_q <= MW'(n_q);
				cnt_q    <= '0;
			end
			V_DIV: begin
				rem_q <= diff[DW+1] ? sh[DW-1:0] : diff[DW-1:0];
				quo_q <= {quo_q[VAR_W-2:0], ~diff[DW+1]};
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q + CNW'(1);
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

endmodule

FILE: rtl/core/laplacian_variance_sharpness.sv
// Top level of the Laplacian-variance sharpness meter.
// Depends on lvs_pkg and lvs_var_unit.

// Pixels of a frame arrive in raster order; each takes a read of the line
// memory at its column, then the window update, accumulation and write-back,
// and in_ready stays low until the write-back is done. On the frame's last
// pixel the iterative variance unit runs, one multiplier or divider bit per
// cycle; no pixel is taken meanwhile. A frame with no interior pixels reports
// zero with no extra delay. The result word sits in an output register, so a
// waiting consumer only stalls the next frame's end. Register writes are
// taken only between pixel words.
module laplacian_variance_sharpness import lvs_pkg::*; #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel,
	input  logic                 frame_start,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [VAR_W-1:0]     variance_q8,
	output logic [CNT_W-1:0]     interior_count,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int TW  = $clog2((MAX_WIDTH - 2) * (MAX_HEIGHT - 2) + 1);
	localparam int SW  = TW + LAP_W;
	localparam int SQW = TW + LAPSQ_W;
	localparam int WCW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int HCW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

	pix_state_t state_q, state_nxt;

	logic [CFG_W-1:0] width_q, height_q;
	logic [CW-1:0]    col_q, col_eff, rd_addr;
	logic [RW-1:0]    row_q, row_eff;
	logic signed [SW-1:0] sum_q, sum_eff, sum_nxt;
	logic [SQW-1:0]   sq_q, sq_eff, sq_nxt;
	logic [TW-1:0]    tally_q, tally_eff, tally_nxt;

	// Line memory: upper byte is the row above, lower byte two rows above
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_q;
	logic [PIX_W-1:0]   above1, above2;

	logic [PIX_W-1:0] pix_s1;
	logic             fs_s1;
	logic [PIX_W-1:0] up_q, mid_l_q, mid_c_q, down_q;

	logic signed [LAP_W-1:0]   lap;
	logic signed [2*LAP_W-1:0] lap_sq;
	logic [WCW-1:0] w_eff;
	logic [HCW-1:0] h_eff;
	logic interior, row_end, frame_end;

	logic [VAR_W-1:0] pend_var_q, vu_quo;
	logic [CNT_W-1:0] pend_cnt_q;
	logic vu_start, vu_done;
	logic emit_go;

	logic             out_valid_q;
	logic [VAR_W-1:0] out_var_q;
	logic [CNT_W-1:0] out_cnt_q;

	// Configuration registers, writable only while no pixel word is in flight
	assign cfg_ready = (state_q == P_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default:          width_q <= width_q;
			endcase
		end
	end

	// Effective frame dimensions: zero acts as one, large values saturate
	always_comb begin
		if (width_q == '0) begin
			w_eff = WCW'(1);
		end else if (WCW'(width_q) > WCW'(MAX_WIDTH)) begin
			w_eff = WCW'(MAX_WIDTH);
		end else begin
			w_eff = WCW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HCW'(1);
		end else if (HCW'(height_q) > HCW'(MAX_HEIGHT)) begin
			h_eff = HCW'(MAX_HEIGHT);
		end else begin
			h_eff = HCW'(height_q);
		end
	end

	// Read address at acceptance; the write-back uses the same column
	assign rd_addr = frame_start ? '0 : col_q;

	always_ff @(posedge clk) begin
		rd_q <= line_mem[rd_addr];
		if (state_q == P_EXEC) begin
			line_mem[col_eff] <= {pix_s1, above1};
		end
	end

	assign above1 = rd_q[2*PIX_W-1:PIX_W];
	assign above2 = rd_q[PIX_W-1:0];

	// Counters and accumulators as seen by the pixel in flight
	always_comb begin
		col_eff   = fs_s1 ? '0 : col_q;
		row_eff   = fs_s1 ? '0 : row_q;
		sum_eff   = fs_s1 ? '0 : sum_q;
		sq_eff    = fs_s1 ? '0 : sq_q;
		tally_eff = fs_s1 ? '0 : tally_q;
	end

	// Four-neighbour Laplacian of the window centre and its square
	always_comb begin
		lap = $signed({1'b0, mid_c_q, 2'b00}) - $signed({3'b000, up_q})
			- $signed({3'b000, down_q}) - $signed({3'b000, mid_l_q})
			- $signed({3'b000, above1});
		lap_sq   = lap * lap;
		interior = (col_eff >= CW'(2)) && (row_eff >= RW'(2));
		sum_nxt   = interior ? sum_eff + SW'(lap) : sum_eff;
		sq_nxt    = interior ? sq_eff + SQW'(lap_sq[LAPSQ_W-1:0]) : sq_eff;
		tally_nxt = interior ? tally_eff + TW'(1) : tally_eff;
		row_end   = (WCW'(col_eff) + WCW'(1)) >= w_eff;
		frame_end = row_end && ((HCW'(row_eff) + HCW'(1)) >= h_eff);
	end

	assign vu_start = (state_q == P_EXEC) && frame_end && (tally_nxt != '0);
	assign emit_go  = (state_q == P_EMIT) && (!out_valid_q || out_ready);

	lvs_var_unit #(
		.TW  (TW),
		.SW  (SW),
		.SQW (SQW)
	) u_var (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (vu_start),
		.n        (tally_nxt),
		.s        (sum_nxt),
		.s2       (sq_nxt),
		.done     (vu_done),
		.quotient (vu_quo)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			P_IDLE: if (in_valid) state_nxt = P_EXEC;
			P_EXEC: begin
				if (vu_start) begin
					state_nxt = P_CALC;
				end else if (frame_end) begin
					state_nxt = P_EMIT;
				end else begin
					state_nxt = P_IDLE;
				end
			end
			P_CALC:  if (vu_done) state_nxt = P_EMIT;
			P_EMIT:  if (emit_go) state_nxt = P_IDLE;
			default: state_nxt = P_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		in_ready       = (state_q == P_IDLE);
		out_valid      = out_valid_q;
		variance_q8    = out_var_q;
		interior_count = out_cnt_q;
	end

	// Control state: sequencer, counters, accumulators, window, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= P_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			tally_q     <= '0;
			up_q        <= '0;
			mid_l_q     <= '0;
			mid_c_q     <= '0;
			down_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == P_EXEC) begin
				up_q    <= above2;
				mid_l_q <= mid_c_q;
				mid_c_q <= above1;
				down_q  <= pix_s1;
				if (frame_end) begin
					col_q   <= '0;
					row_q   <= '0;
					sum_q   <= '0;
					sq_q    <= '0;
					tally_q <= '0;
				end else begin
					sum_q   <= sum_nxt;
					sq_q    <= sq_nxt;
					tally_q <= tally_nxt;
					if (row_end) begin
						col_q <= '0;
						row_q <= row_eff + RW'(1);
					end else begin
						col_q <= col_eff + CW'(1);
						row_q <= row_eff;
					end
				end
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pix_s1 <= pixel;
			fs_s1  <= frame_start;
		end
		if (state_q == P_EXEC && frame_end) begin
			pend_var_q <= '0;
			pend_cnt_q <= CNT_W'(tally_nxt);
		end
		if (state_q == P_CALC && vu_done) begin
			pend_var_q <= vu_quo;
		end
		if (emit_go) begin
			out_var_q <= pend_var_q;
			out_cnt_q <= pend_cnt_q;
		end
	end

	// The variance unit finishes only while the sequencer waits for it
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		vu_done |-> state_q == P_CALC)
		else $error("variance unit finished outside the wait state");

	// Waiting for the unit leads only to the result emission
	a_calc_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == P_CALC |=> (state_q == P_CALC || state_q == P_EMIT))
		else $error("left the variance wait without emitting");

	// An accepted word is processed in the following cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == P_EXEC)
		else $error("accepted pixel word not processed");

	// A result word is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_var_q))
		else $error("pending result word was overwritten");

endmodule
